// ===== sv/pearson_correlation_unit_macros.svh =====
// assertion macros for the correlation unit
`ifndef PEARSON_CORRELATION_UNIT_MACROS_SVH
`define PEARSON_CORRELATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk_i, off during reset
`define PCU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCU_ASSERT_IMP(lbl, ante, cons, msg)
`define PCU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/pcu_pkg.sv =====
package pcu_pkg;

  // widths of the running sums, sized for the largest run
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned SUM_W  = 33;
  localparam int unsigned SQ_W   = 47;
  localparam int unsigned PRD_W  = 48;
  localparam int unsigned ACC_W  = 128;
  localparam int unsigned ROOT_W = 160;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SQ_W-1:0]  sum_xx;
    logic [SQ_W-1:0]  sum_yy;
    logic [PRD_W-1:0] sum_xy;
    logic             overflow;
  } pcu_sums_t;

  typedef struct packed {
    logic [15:0] correlation;
    logic [15:0] mean_x;
    logic [30:0] variance_x;
    logic [15:0] mean_y;
    logic [30:0] variance_y;
    logic        zero_spread;
    logic        too_few_samples;
    logic        count_overflow;
  } pcu_result_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } pcu_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_ISSUE,
    ST_MUL_ADD,
    ST_RETIRE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ROOT_ADD,
    ST_ROOT_CMP,
    ST_DONE
  } pcu_state_e;

  typedef enum logic [3:0] {
    PH_NSXX,
    PH_SXSX,
    PH_NSYY,
    PH_SYSY,
    PH_NSXY,
    PH_SXSY,
    PH_NN1,
    PH_MEANX,
    PH_MEANY,
    PH_VARX,
    PH_VARY,
    PH_PXY,
    PH_CSQ,
    PH_ROOT
  } pcu_phase_e;

endpackage

// ===== sv/pcu_sample_if.sv =====
interface pcu_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  logic               last_sample;

  modport source (output valid, x_sample, y_sample, last_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, last_sample, output ready);
endinterface

// ===== sv/pcu_result_if.sv =====
interface pcu_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] correlation;
  logic signed [15:0] mean_x;
  logic        [30:0] variance_x;
  logic signed [15:0] mean_y;
  logic        [30:0] variance_y;
  logic               zero_spread;
  logic               too_few_samples;
  logic               count_overflow;

  modport source (output valid, correlation, mean_x, variance_x, mean_y, variance_y,
                  zero_spread, too_few_samples, count_overflow, input ready);
  modport sink   (input valid, correlation, mean_x, variance_x, mean_y, variance_y,
                  zero_spread, too_few_samples, count_overflow, output ready);
endinterface

// ===== sv/pcu_mul.sv =====
module pcu_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // registered 32x32 partial product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/pcu_div.sv =====
module pcu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [32:0] rem_q;
  logic [63:0] quo_q;
  logic [32:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [33:0] shifted;
  logic        fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[63]};
    fits    = shifted >= {1'b0, dsr_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 33'(shifted - {1'b0, dsr_q}) : shifted[32:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/pcu_seq.sv =====
module pcu_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                take_i,
  input  pcu_pkg::pcu_sums_t  sums_i,
  output pcu_pkg::pcu_status_t status_o,
  output pcu_pkg::pcu_result_t result_o
);

  localparam int unsigned RW = pcu_pkg::ROOT_W;

  pcu_pkg::pcu_state_e state_q, state_d;
  pcu_pkg::pcu_phase_e phase_q, phase_nxt;

  logic [1:0]  mstep_q;
  logic [127:0] acc_q;
  logic [63:0] dx_q, dy_q, c_q;
  logic [32:0] den_q;
  logic [127:0] p_q;
  logic [RW-1:0] r_q, a_q, e_q, f_q, t_q;
  logic [15:0] qv_q;
  logic [3:0]  k_q;
  pcu_pkg::pcu_result_t res_q;

  logic [63:0] n64, op_a, op_b, div_a, quot;
  logic [32:0] div_b;
  logic [32:0] sx_abs, sy_abs;
  logic [47:0] sxy_abs;
  logic        sx_neg, sy_neg, sxy_neg, c_neg;
  logic [63:0] c_abs, prod_lo, pp;
  logic [31:0] mul_a, mul_b;
  logic [127:0] pp_sh;
  logic        div_start, div_done;
  logic [RW-1:0] tf;
  logic        ok, few, flat;
  logic [15:0] q_fin, corr;

  // operand magnitudes and signs
  always_comb begin
    n64     = 64'(sums_i.count);
    sx_neg  = sums_i.sum_x[pcu_pkg::SUM_W-1];
    sy_neg  = sums_i.sum_y[pcu_pkg::SUM_W-1];
    sxy_neg = sums_i.sum_xy[pcu_pkg::PRD_W-1];
    sx_abs  = sx_neg ? (~sums_i.sum_x + 33'd1) : sums_i.sum_x;
    sy_abs  = sy_neg ? (~sums_i.sum_y + 33'd1) : sums_i.sum_y;
    sxy_abs = sxy_neg ? (~sums_i.sum_xy + 48'd1) : sums_i.sum_xy;
    c_neg   = c_q[63];
    c_abs   = c_neg ? (~c_q + 64'd1) : c_q;
    few     = sums_i.count < pcu_pkg::CNT_W'(2);
    flat    = (dx_q == 64'd0) || (dy_q == 64'd0);
    prod_lo = acc_q[63:0];
  end

  // wide multiply operands per phase
  always_comb begin
    case (phase_q)
      pcu_pkg::PH_NSXX: begin op_a = n64;          op_b = 64'(sums_i.sum_xx); end
      pcu_pkg::PH_SXSX: begin op_a = 64'(sx_abs);  op_b = 64'(sx_abs);        end
      pcu_pkg::PH_NSYY: begin op_a = n64;          op_b = 64'(sums_i.sum_yy); end
      pcu_pkg::PH_SYSY: begin op_a = 64'(sy_abs);  op_b = 64'(sy_abs);        end
      pcu_pkg::PH_NSXY: begin op_a = n64;          op_b = 64'(sxy_abs);       end
      pcu_pkg::PH_SXSY: begin op_a = 64'(sx_abs);  op_b = 64'(sy_abs);        end
      pcu_pkg::PH_NN1:  begin op_a = n64;          op_b = n64 - 64'd1;        end
      pcu_pkg::PH_PXY:  begin op_a = dx_q;         op_b = dy_q;               end
      pcu_pkg::PH_CSQ:  begin op_a = c_abs;        op_b = c_abs;              end
      default:          begin op_a = '0;           op_b = '0;                 end
    endcase
    mul_a = mstep_q[1] ? op_a[63:32] : op_a[31:0];
    mul_b = mstep_q[0] ? op_b[63:32] : op_b[31:0];
  end

  pcu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (pp)
  );

  // partial product alignment
  always_comb begin
    if (mstep_q[1] && mstep_q[0]) begin
      pp_sh = {pp, 64'd0};
    end else if (mstep_q[1] || mstep_q[0]) begin
      pp_sh = {32'd0, pp, 32'd0};
    end else begin
      pp_sh = {64'd0, pp};
    end
  end

  // divider operands per phase
  always_comb begin
    case (phase_q)
      pcu_pkg::PH_MEANX: begin div_a = 64'(sx_abs); div_b = 33'(sums_i.count); end
      pcu_pkg::PH_MEANY: begin div_a = 64'(sy_abs); div_b = 33'(sums_i.count); end
      pcu_pkg::PH_VARX:  begin div_a = dx_q;        div_b = den_q;             end
      pcu_pkg::PH_VARY:  begin div_a = dy_q;        div_b = den_q;             end
      default:           begin div_a = '0;          div_b = '0;                end
    endcase
    div_start = state_q == pcu_pkg::ST_DIV_START;
  end

  pcu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // root search trial and final coefficient
  always_comb begin
    tf    = t_q + f_q;
    ok    = tf <= r_q;
    q_fin = qv_q | (16'(ok) << k_q);
    if (c_neg) begin
      corr = ~q_fin + 16'd1;
    end else begin
      corr = q_fin[15] ? 16'h7fff : q_fin;
    end
  end

  // phase order
  always_comb begin
    case (phase_q)
      pcu_pkg::PH_NSXX:  phase_nxt = pcu_pkg::PH_SXSX;
      pcu_pkg::PH_SXSX:  phase_nxt = pcu_pkg::PH_NSYY;
      pcu_pkg::PH_NSYY:  phase_nxt = pcu_pkg::PH_SYSY;
      pcu_pkg::PH_SYSY:  phase_nxt = pcu_pkg::PH_NSXY;
      pcu_pkg::PH_NSXY:  phase_nxt = pcu_pkg::PH_SXSY;
      pcu_pkg::PH_SXSY:  phase_nxt = pcu_pkg::PH_NN1;
      pcu_pkg::PH_NN1:   phase_nxt = pcu_pkg::PH_MEANX;
      pcu_pkg::PH_MEANX: phase_nxt = pcu_pkg::PH_MEANY;
      pcu_pkg::PH_MEANY: phase_nxt = pcu_pkg::PH_VARX;
      pcu_pkg::PH_VARX:  phase_nxt = pcu_pkg::PH_VARY;
      pcu_pkg::PH_VARY:  phase_nxt = pcu_pkg::PH_PXY;
      pcu_pkg::PH_PXY:   phase_nxt = pcu_pkg::PH_CSQ;
      pcu_pkg::PH_CSQ:   phase_nxt = pcu_pkg::PH_ROOT;
      default:           phase_nxt = pcu_pkg::PH_NSXX;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcu_pkg::ST_IDLE:      if (start_i) state_d = pcu_pkg::ST_LOAD;
      pcu_pkg::ST_LOAD:      state_d = few ? pcu_pkg::ST_DONE : pcu_pkg::ST_MUL_ISSUE;
      pcu_pkg::ST_MUL_ISSUE: state_d = pcu_pkg::ST_MUL_ADD;
      pcu_pkg::ST_MUL_ADD: begin
        state_d = (mstep_q == 2'd3) ? pcu_pkg::ST_RETIRE : pcu_pkg::ST_MUL_ISSUE;
      end
      pcu_pkg::ST_RETIRE: begin
        case (phase_q)
          pcu_pkg::PH_NN1: state_d = pcu_pkg::ST_DIV_START;
          pcu_pkg::PH_CSQ: state_d = pcu_pkg::ST_ROOT_ADD;
          default:         state_d = pcu_pkg::ST_MUL_ISSUE;
        endcase
      end
      pcu_pkg::ST_DIV_START: state_d = pcu_pkg::ST_DIV_WAIT;
      pcu_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (phase_q == pcu_pkg::PH_VARY) begin
            state_d = flat ? pcu_pkg::ST_DONE : pcu_pkg::ST_MUL_ISSUE;
          end else begin
            state_d = pcu_pkg::ST_DIV_START;
          end
        end
      end
      pcu_pkg::ST_ROOT_ADD:  state_d = pcu_pkg::ST_ROOT_CMP;
      pcu_pkg::ST_ROOT_CMP:  if (k_q == 4'd0) state_d = pcu_pkg::ST_DONE;
                             else state_d = pcu_pkg::ST_ROOT_ADD;
      pcu_pkg::ST_DONE:      if (take_i) state_d = pcu_pkg::ST_IDLE;
      default:               state_d = pcu_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcu_pkg::ST_IDLE;
      phase_q <= pcu_pkg::PH_NSXX;
      mstep_q <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        pcu_pkg::ST_LOAD: begin
          phase_q <= pcu_pkg::PH_NSXX;
          mstep_q <= '0;
        end
        pcu_pkg::ST_MUL_ADD:  mstep_q <= mstep_q + 2'd1;
        pcu_pkg::ST_RETIRE: begin
          phase_q <= phase_nxt;
          k_q     <= 4'd15;
        end
        pcu_pkg::ST_DIV_WAIT: if (div_done) phase_q <= phase_nxt;
        pcu_pkg::ST_ROOT_CMP: k_q <= k_q - 4'd1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pcu_pkg::ST_LOAD: begin
        acc_q <= '0;
        res_q <= '{too_few_samples: few, count_overflow: sums_i.overflow, default: '0};
      end
      pcu_pkg::ST_MUL_ADD: acc_q <= acc_q + pp_sh;
      pcu_pkg::ST_RETIRE: begin
        acc_q <= '0;
        case (phase_q)
          pcu_pkg::PH_NSXX: dx_q <= prod_lo;
          pcu_pkg::PH_SXSX: dx_q <= dx_q - prod_lo;
          pcu_pkg::PH_NSYY: dy_q <= prod_lo;
          pcu_pkg::PH_SYSY: dy_q <= dy_q - prod_lo;
          pcu_pkg::PH_NSXY: c_q  <= sxy_neg ? (~prod_lo + 64'd1) : prod_lo;
          pcu_pkg::PH_SXSY: c_q  <= (sx_neg ^ sy_neg) ? (c_q + prod_lo) : (c_q - prod_lo);
          pcu_pkg::PH_NN1:  den_q <= acc_q[32:0];
          pcu_pkg::PH_PXY:  p_q  <= acc_q;
          pcu_pkg::PH_CSQ: begin
            r_q  <= RW'(acc_q) << 30;
            a_q  <= '0;
            e_q  <= '0;
            t_q  <= '0;
            f_q  <= RW'(p_q) << 30;
            qv_q <= '0;
          end
          default: ;
        endcase
      end
      pcu_pkg::ST_DIV_WAIT: begin
        acc_q <= '0;
        if (div_done) begin
          case (phase_q)
            pcu_pkg::PH_MEANX: res_q.mean_x <= sx_neg ? (~quot[15:0] + 16'd1) : quot[15:0];
            pcu_pkg::PH_MEANY: res_q.mean_y <= sy_neg ? (~quot[15:0] + 16'd1) : quot[15:0];
            pcu_pkg::PH_VARX: begin
              res_q.variance_x <= (|quot[63:31]) ? 31'h7fffffff : quot[30:0];
            end
            pcu_pkg::PH_VARY: begin
              res_q.variance_y  <= (|quot[63:31]) ? 31'h7fffffff : quot[30:0];
              res_q.zero_spread <= flat;
            end
            default: ;
          endcase
        end
      end
      pcu_pkg::ST_ROOT_ADD: t_q <= a_q + e_q;
      pcu_pkg::ST_ROOT_CMP: begin
        if (ok) begin
          a_q <= tf;
          e_q <= (e_q >> 1) + f_q;
        end else begin
          e_q <= e_q >> 1;
        end
        f_q  <= f_q >> 2;
        qv_q <= q_fin;
        if (k_q == 4'd0) res_q.correlation <= corr;
      end
      default: ;
    endcase
  end

  assign status_o.idle      = state_q == pcu_pkg::ST_IDLE;
  assign status_o.res_valid = state_q == pcu_pkg::ST_DONE;
  assign result_o           = res_q;

endmodule

// ===== sv/pearson_correlation_unit.sv =====
// Pearson correlation unit: takes signed Q8.8 pairs (x, y), one per cycle, and keeps
// the pair count and running sums of x, y, x*x, y*y and x*y. The pair marked last ends
// the run: the block then stops taking pairs while one 32x32 multiplier (nine 64x64
// products, four partials each), a one-bit-per-cycle divider (four divisions) and a
// 16-step coefficient search produce the means, the sample variances over n-1 and the
// coefficient in Q1.15. A run with fewer than two pairs skips the arithmetic and only
// flags too_few_samples. The sums clear when the result is handed over; the next
// run's pairs are taken as soon as the result sits in the output register.
`include "pearson_correlation_unit_macros.svh"

module pearson_correlation_unit #(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcu_sample_if.sink   sample_i,
  pcu_result_if.source result_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);

  logic [CntW-1:0]              cnt_q;
  logic [pcu_pkg::SUM_W-1:0]    sx_q, sy_q;
  logic [pcu_pkg::SQ_W-1:0]     sxx_q, syy_q;
  logic [pcu_pkg::PRD_W-1:0]    sxy_q;
  logic                         ovf_q;
  logic                         out_valid_q;
  pcu_pkg::pcu_result_t         out_q;

  pcu_pkg::pcu_sums_t           sums;
  pcu_pkg::pcu_status_t         status;
  pcu_pkg::pcu_result_t         res;
  logic                         accept, take, start;
  logic signed [31:0]           xx, yy, xy;

  assign accept = sample_i.valid && sample_i.ready;
  assign start  = accept && sample_i.last_sample;
  assign take   = status.res_valid && (!out_valid_q || result_o.ready);
  assign sample_i.ready = status.idle;

  // per-beat products
  always_comb begin
    xx = sample_i.x_sample * sample_i.x_sample;
    yy = sample_i.y_sample * sample_i.y_sample;
    xy = sample_i.x_sample * sample_i.y_sample;
  end

  // running sums, cleared when the result is handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (take) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (cnt_q < CntW'(MAX_SAMPLES)) begin
        cnt_q <= cnt_q + CntW'(1);
        sx_q  <= sx_q + pcu_pkg::SUM_W'(sample_i.x_sample);
        sy_q  <= sy_q + pcu_pkg::SUM_W'(sample_i.y_sample);
        sxx_q <= sxx_q + pcu_pkg::SQ_W'(xx[30:0]);
        syy_q <= syy_q + pcu_pkg::SQ_W'(yy[30:0]);
        sxy_q <= sxy_q + pcu_pkg::PRD_W'(xy);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_comb begin
    sums.count    = pcu_pkg::CNT_W'(cnt_q);
    sums.sum_x    = sx_q;
    sums.sum_y    = sy_q;
    sums.sum_xx   = sxx_q;
    sums.sum_yy   = syy_q;
    sums.sum_xy   = sxy_q;
    sums.overflow = ovf_q;
  end

  pcu_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .take_i   (take),
    .sums_i   (sums),
    .status_o (status),
    .result_o (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.correlation     = out_q.correlation;
  assign result_o.mean_x          = out_q.mean_x;
  assign result_o.variance_x      = out_q.variance_x;
  assign result_o.mean_y          = out_q.mean_y;
  assign result_o.variance_y      = out_q.variance_y;
  assign result_o.zero_spread     = out_q.zero_spread;
  assign result_o.too_few_samples = out_q.too_few_samples;
  assign result_o.count_overflow  = out_q.count_overflow;

  // checks
  `PCU_ASSERT_IMP(a_few_zero, result_o.valid && result_o.too_few_samples, result_o.correlation == 16'sd0 && result_o.variance_x == 31'd0 && result_o.zero_spread == 1'b0, "too few pairs but nonzero result")
  `PCU_ASSERT_IMP(a_flat_zero, result_o.valid && result_o.zero_spread, result_o.correlation == 16'sd0, "zero spread but nonzero coefficient")
  `PCU_ASSERT_NEXT(a_last_stops, start, !sample_i.ready, "input still open after last beat")
  `PCU_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CntW'(MAX_SAMPLES), "pair count past limit")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_PAIRS   = 65536;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 500;

  logic clk_i;
  logic rst_ni;

  pcu_sample_if smp ();
  pcu_result_if res ();

  pearson_correlation_unit #(.MAX_SAMPLES(MAX_PAIRS)) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res)
  );

  // directed stimulus row; a typed result replaces the computed one when present
  typedef struct {
    logic signed [15:0]   x;
    logic signed [15:0]   y;
    logic                 last;
    bit                   typed;
    pcu_pkg::pcu_result_t want;
  } pair_row_t;

  // running sums of the current run
  longint      run_count;
  longint      run_sx, run_sy, run_sxx, run_syy, run_sxy;
  bit          run_ovf;
  pcu_pkg::pcu_result_t stats_q[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  errors;
  int  quiet_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // largest q with q*q*dx*dy <= mag*mag*2^30, q at most 32768
  function automatic int unsigned coef_search(longint dx, longint dy, longint mag);
    logic [255:0] prod, rhs, lhs;
    int unsigned lo, hi, mid;
    prod = 256'(dx) * 256'(dy);
    rhs  = (256'(mag) * 256'(mag)) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 256'(mid) * 256'(mid) * prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [30:0] spread_over_n1(longint d, longint n);
    longint v;
    v = d / (n * (n - 1));
    return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
  endfunction

  // accumulate one pair, return 1 with the statistics when the run ends
  function automatic bit fold_pair(logic signed [15:0] x, logic signed [15:0] y, logic last,
                                   output pcu_pkg::pcu_result_t r);
    longint xv, yv, dx, dy, c, mag;
    int unsigned q;
    xv = x;
    yv = y;
    r = '0;
    if (run_count < MAX_PAIRS) begin
      run_count++;
      run_sx  += xv;
      run_sy  += yv;
      run_sxx += xv * xv;
      run_syy += yv * yv;
      run_sxy += xv * yv;
    end else begin
      run_ovf = 1'b1;
    end
    if (!last) return 1'b0;
    r.count_overflow = run_ovf;
    if (run_count < 2) begin
      r.too_few_samples = 1'b1;
    end else begin
      dx = run_count * run_sxx - run_sx * run_sx;
      dy = run_count * run_syy - run_sy * run_sy;
      c  = run_count * run_sxy - run_sx * run_sy;
      r.mean_x     = 16'(run_sx / run_count);
      r.mean_y     = 16'(run_sy / run_count);
      r.variance_x = spread_over_n1(dx, run_count);
      r.variance_y = spread_over_n1(dy, run_count);
      if (dx == 0 || dy == 0) begin
        r.zero_spread = 1'b1;
      end else begin
        mag = (c < 0) ? -c : c;
        q = coef_search(dx, dy, mag);
        if (c < 0) r.correlation = 16'(-((q > 32768) ? 32768 : int'(q)));
        else r.correlation = 16'((q > 32767) ? 32767 : q);
      end
    end
    run_count = 0;
    run_sx = 0; run_sy = 0; run_sxx = 0; run_syy = 0; run_sxy = 0;
    run_ovf = 1'b0;
    return 1'b1;
  endfunction

  // drive one beat and wait for it to be taken
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last,
                           bit typed, pcu_pkg::pcu_result_t want);
    pcu_pkg::pcu_result_t r;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    smp.valid       = 1'b1;
    smp.x_sample    = x;
    smp.y_sample    = y;
    smp.last_sample = last;
    do @(posedge clk_i); while (!smp.ready);
    if (fold_pair(x, y, last, r)) stats_q.push_back(typed ? want : r);
    @(negedge clk_i);
    smp.valid       = 1'b0;
    smp.x_sample    = 16'($urandom);
    smp.y_sample    = 16'($urandom);
    smp.last_sample = 1'($urandom_range(1));
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_runs(int pairs);
    int len;
    logic signed [15:0] x, y;
    while (pairs > 0) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = $urandom_range(30, 60);
        default: len = $urandom_range(2, 12);
      endcase
      for (int i = 0; i < len; i++) begin
        x = pick_value();
        // mostly related y so the coefficient spreads over its range
        case ($urandom_range(3))
          0: y = x;
          1: y = -x;
          2: y = 16'((int'(x) >>> 1) + int'($urandom_range(255)) - 128);
          default: y = pick_value();
        endcase
        send_pair(x, y, i == len - 1, 1'b0, '0);
      end
      pairs -= len;
    end
  endtask

  task automatic chk(string name, logic [30:0] want, logic [30:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: random back-pressure, compare each beat with the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni) res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    pcu_pkg::pcu_result_t w;
    if (rst_ni && res.valid && res.ready) begin
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual corr %h", $time, res.correlation);
        errors++;
      end else begin
        w = stats_q.pop_front();
        chk("correlation", 31'(w.correlation), 31'($unsigned(res.correlation)));
        chk("mean_x", 31'(w.mean_x), 31'($unsigned(res.mean_x)));
        chk("variance_x", w.variance_x, res.variance_x);
        chk("mean_y", 31'(w.mean_y), 31'($unsigned(res.mean_y)));
        chk("variance_y", w.variance_y, res.variance_y);
        chk("zero_spread", 31'(w.zero_spread), 31'(res.zero_spread));
        chk("too_few_samples", 31'(w.too_few_samples), 31'(res.too_few_samples));
        chk("count_overflow", 31'(w.count_overflow), 31'(res.count_overflow));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    pair_row_t            rows[$];
    pcu_pkg::pcu_result_t few, flat;

    smp.valid = 1'b0;
    smp.x_sample = '0;
    smp.y_sample = '0;
    smp.last_sample = 1'b0;
    res.ready = 1'b0;
    rst_ni = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_count = 0;
    run_sx = 0; run_sy = 0; run_sxx = 0; run_syy = 0; run_sxy = 0;
    run_ovf = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    few = '0;
    few.too_few_samples = 1'b1;
    // x constant: dx zero, y spread 100 over n*(n-1)
    flat = '0;
    flat.mean_x = 16'sd5;
    flat.mean_y = 16'sd2;
    flat.variance_y = 31'd50;
    flat.zero_spread = 1'b1;

    rows = '{
      '{16'sd0, 16'sd0, 1'b1, 1'b1, few},
      '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, few},
      '{16'sd5, 16'sd7, 1'b0, 1'b0, '0},
      '{16'sd5, -16'sd3, 1'b1, 1'b1, flat},
      '{16'sd256, 16'sd256, 1'b0, 1'b0, '0},
      '{16'sd512, 16'sd512, 1'b1, 1'b0, '0},
      '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{16'sh7FFF, 16'sh8000, 1'b1, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 1'b0, 1'b0, '0},
      '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{16'sd0, 16'sd0, 1'b1, 1'b0, '0},
      '{-16'sd1, 16'sd1, 1'b0, 1'b0, '0},
      '{16'sd1, -16'sd1, 1'b1, 1'b0, '0},
      '{16'sd100, -16'sd7, 1'b0, 1'b0, '0},
      '{-16'sd300, 16'sd9000, 1'b0, 1'b0, '0},
      '{16'sd4000, 16'sd12, 1'b1, 1'b0, '0},
      '{16'sh5555, 16'shAAAA, 1'b0, 1'b0, '0},
      '{16'shAAAA, 16'sh5555, 1'b1, 1'b0, '0}
    };
    foreach (rows[i]) send_pair(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                                rows[i].want);

    // random runs under each idling mix
    send_idle_pct = 0;  recv_stall_pct = 0;  random_runs(175);
    send_idle_pct = 88; recv_stall_pct = 0;  random_runs(175);
    send_idle_pct = 0;  recv_stall_pct = 88; random_runs(175);
    send_idle_pct = 26; recv_stall_pct = 26; random_runs(175);
    send_idle_pct = 0;  recv_stall_pct = 0;

    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pcu_pkg.sv
sv/pcu_sample_if.sv
sv/pcu_result_if.sv
sv/pcu_mul.sv
sv/pcu_div.sv
sv/pcu_seq.sv
sv/pearson_correlation_unit.sv
dv/tb_top.sv
